@@ sv/tcf_pkg.sv @@
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types, constants and helper functions of the tilt complementary filter.
// ----------------------------------------------------------------------------
package tcf_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TBL_LEN          = 24;
	localparam int TBL_IW           = 5;
	localparam int CW               = 28;
	localparam int GYRO_HALF        = 65500;

	// 131000 = 8 * 16375; floor(2^42 / 16375)
	localparam logic [13:0] GYRO_DIV8  = 14'd16375;
	localparam logic [28:0] GYRO_RECIP = 29'd268582993;

	localparam logic [15:0]        BLEND_RST        = 16'd64225;
	localparam logic signed [14:0] ACC_ROLL_TRIM_RST  = -15'sd1536;
	localparam logic signed [14:0] ACC_PITCH_TRIM_RST = -15'sd3584;
	localparam logic signed [14:0] GYR_ROLL_TRIM_RST  = -15'sd2048;
	localparam logic signed [14:0] GYR_PITCH_TRIM_RST = 15'sd512;

	typedef enum logic [2:0] {
		REG_BLEND      = 3'd0,
		REG_ACC_ROLL   = 3'd1,
		REG_ACC_PITCH  = 3'd2,
		REG_GYR_ROLL   = 3'd3,
		REG_GYR_PITCH  = 3'd4,
		REG_MOUNT_ROLL = 3'd5,
		REG_MOUNT_PITCH= 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROT_R,
		ST_PITCH,
		ST_ROT_P,
		ST_ANG,
		ST_MUL,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic              start;
		logic              rot;
		logic [TBL_IW-1:0] idx;
		logic              save_roll;
		logic              save_pitch;
		logic              mul;
		logic              commit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

	// arctangent of 2^-i in degrees, Q16
	function automatic logic signed [CW-1:0] atan_q16(input logic [TBL_IW-1:0] i);
		logic signed [CW-1:0] r;
		case (i)
			5'd0:    r = 28'sd2949120;
			5'd1:    r = 28'sd1740967;
			5'd2:    r = 28'sd919879;
			5'd3:    r = 28'sd466945;
			5'd4:    r = 28'sd234379;
			5'd5:    r = 28'sd117304;
			5'd6:    r = 28'sd58666;
			5'd7:    r = 28'sd29335;
			5'd8:    r = 28'sd14668;
			5'd9:    r = 28'sd7334;
			5'd10:   r = 28'sd3667;
			5'd11:   r = 28'sd1833;
			5'd12:   r = 28'sd917;
			5'd13:   r = 28'sd458;
			5'd14:   r = 28'sd229;
			5'd15:   r = 28'sd115;
			5'd16:   r = 28'sd57;
			5'd17:   r = 28'sd29;
			5'd18:   r = 28'sd14;
			5'd19:   r = 28'sd7;
			5'd20:   r = 28'sd4;
			5'd21:   r = 28'sd2;
			5'd22:   r = 28'sd1;
			default: r = 28'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [16:0] sat17(input logic signed [39:0] v);
		logic signed [16:0] r;
		if (v > 40'sd65535)
			r = 17'sd65535;
		else if (v < -40'sd65536)
			r = -17'sd65536;
		else
			r = v[16:0];
		return r;
	endfunction

endpackage

@@ sv/tcf_gyro_div.sv @@
// ----------------------------------------------------------------------------
// tcf_gyro_div
// Gyro angle increment: rate*ms*256/131000, rounded half away from zero,
// by reciprocal multiplication and one correction step.
// ----------------------------------------------------------------------------
module tcf_gyro_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] rate,
	input  logic [15:0]        ms,
	output logic               done,
	output logic signed [23:0] inc
);
	import tcf_pkg::*;

	logic signed [32:0] prod_q;
	logic               init_q;
	logic               vld_s1;
	logic               vld_s2;
	logic               vld_s3;
	logic               done_q;
	logic               neg_q;
	logic [35:0]        n8_s1;
	logic [22:0]        est_s2;
	logic [15:0]        rem_s3;
	logic [22:0]        quo_q;

	logic signed [32:0] prod;
	logic [32:0]        mag;
	logic [39:0]        num_full;
	logic [60:0]        recip_prod;
	logic [36:0]        back_prod;
	logic [35:0]        rem_full;

	assign prod       = rate * $signed({1'b0, ms});
	assign mag        = prod_q[32] ? 33'(-prod_q) : 33'(prod_q);
	assign num_full   = {mag[31:0], 8'b0} + 40'(GYRO_HALF);
	// estimate is low by at most one
	assign recip_prod = n8_s1[35:4] * GYRO_RECIP;
	assign back_prod  = est_s2 * GYRO_DIV8;
	assign rem_full   = n8_s1 - back_prod[35:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			init_q <= start;
			vld_s1 <= init_q;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (start)
				done_q <= 1'b0;
			else if (vld_s3)
				done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			prod_q <= prod;
		if (init_q) begin
			neg_q <= prod_q[32];
			n8_s1 <= num_full[38:3];
		end
		if (vld_s1)
			est_s2 <= recip_prod[60:38];
		if (vld_s2)
			rem_s3 <= rem_full[15:0];
		if (vld_s3)
			quo_q <= est_s2 + 23'(rem_s3 >= 16'(GYRO_DIV8));
	end

	assign done = done_q;
	assign inc  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

@@ sv/tcf_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcf_ctrl
// Sequencer: roll CORDIC, pitch CORDIC, blend multiply, commit to output.
// ----------------------------------------------------------------------------
module tcf_ctrl #(
	parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  tcf_pkg::sts_t sts,
	output tcf_pkg::cmd_t cmd
);
	import tcf_pkg::*;

	localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	state_t        state_q, state_d;
	logic [SW-1:0] cnt_q, cnt_d;
	logic          m_tvalid_q;
	logic          last;
	logic          out_free;

	assign last     = cnt_q == SW'(CORDIC_STEPS - 1);
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.commit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.idx  = TBL_IW'(cnt_q);
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cnt_d    = '0;
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_d   = ST_ROT_R;
				end
			end
			ST_ROT_R: begin
				cmd.rot = 1'b1;
				cnt_d   = cnt_q + SW'(1);
				if (last) begin
					cnt_d   = '0;
					state_d = ST_PITCH;
				end
			end
			ST_PITCH: begin
				cmd.save_roll = 1'b1;
				state_d       = ST_ROT_P;
			end
			ST_ROT_P: begin
				cmd.rot = 1'b1;
				cnt_d   = cnt_q + SW'(1);
				if (last) begin
					cnt_d   = '0;
					state_d = ST_ANG;
				end
			end
			ST_ANG: begin
				cmd.save_pitch = 1'b1;
				if (sts.div_done)
					state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = m_tvalid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_tvalid_q || m_tready))
		else $error("result overwritten while pending");

	a_start_rot: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_ROT_R && cnt_q == '0))
		else $error("accepted item did not start rotation");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROT_R || state_q == ST_ROT_P) |-> (cnt_q <= SW'(CORDIC_STEPS - 1)))
		else $error("rotation counter out of range");

	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> sts.div_done)
		else $error("blend started before gyro increment ready");

endmodule

@@ sv/tcf_datapath.sv @@
// ----------------------------------------------------------------------------
// tcf_datapath
// Configuration registers, shared CORDIC atan2, gyro dividers, blend and state.
// ----------------------------------------------------------------------------
module tcf_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  tcf_pkg::cmd_t      cmd,
	output tcf_pkg::sts_t      sts,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_addr,
	input  logic [15:0]        cfg_wdata,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	input  logic signed [15:0] gyro_z,
	input  logic [15:0]        elapsed_ms,
	output logic signed [16:0] roll_angle,
	output logic signed [16:0] pitch_angle,
	output logic signed [16:0] yaw_angle
);
	import tcf_pkg::*;

	logic [15:0]        blend_q;
	logic signed [14:0] acc_roll_trim_q, acc_pitch_trim_q;
	logic signed [14:0] gyr_roll_trim_q, gyr_pitch_trim_q;
	logic signed [14:0] mount_roll_q, mount_pitch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_q          <= BLEND_RST;
			acc_roll_trim_q  <= ACC_ROLL_TRIM_RST;
			acc_pitch_trim_q <= ACC_PITCH_TRIM_RST;
			gyr_roll_trim_q  <= GYR_ROLL_TRIM_RST;
			gyr_pitch_trim_q <= GYR_PITCH_TRIM_RST;
			mount_roll_q     <= '0;
			mount_pitch_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BLEND:       blend_q          <= cfg_wdata;
				REG_ACC_ROLL:    acc_roll_trim_q  <= cfg_wdata[14:0];
				REG_ACC_PITCH:   acc_pitch_trim_q <= cfg_wdata[14:0];
				REG_GYR_ROLL:    gyr_roll_trim_q  <= cfg_wdata[14:0];
				REG_GYR_PITCH:   gyr_pitch_trim_q <= cfg_wdata[14:0];
				REG_MOUNT_ROLL:  mount_roll_q     <= cfg_wdata[14:0];
				REG_MOUNT_PITCH: mount_pitch_q    <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	// gyro increments
	logic               done_x, done_y, done_z;
	logic signed [23:0] inc_x, inc_y, inc_z;

	tcf_gyro_div u_div_x (.clk, .arst_n, .start(cmd.start), .rate(gyro_x),
		.ms(elapsed_ms), .done(done_x), .inc(inc_x));
	tcf_gyro_div u_div_y (.clk, .arst_n, .start(cmd.start), .rate(gyro_y),
		.ms(elapsed_ms), .done(done_y), .inc(inc_y));
	tcf_gyro_div u_div_z (.clk, .arst_n, .start(cmd.start), .rate(gyro_z),
		.ms(elapsed_ms), .done(done_z), .inc(inc_z));

	assign sts.div_done = done_x && done_y && done_z;

	// CORDIC vectoring
	logic signed [15:0]   ax_q, az_q;
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic                 zero_q;

	logic signed [15:0]   lx, ly;
	logic                 lneg;
	logic signed [16:0]   lx2, ly2;
	logic signed [CW-1:0] x_ld, y_ld, z_ld;
	logic signed [CW-1:0] xs, ys, at;
	logic signed [CW-1:0] ang_full;
	logic signed [19:0]   ang;
	logic signed [16:0]   acc_r, acc_p;

	assign lx   = cmd.start ? accel_z : az_q;
	assign ly   = cmd.start ? accel_y : ax_q;
	assign lneg = lx[15];
	assign lx2  = lneg ? -17'(lx) : 17'(lx);
	assign ly2  = lneg ? -17'(ly) : 17'(ly);
	assign x_ld = $signed({{3{lx2[16]}}, lx2, 8'b0});
	assign y_ld = $signed({{3{ly2[16]}}, ly2, 8'b0});
	assign z_ld = !lneg ? '0 : (ly[15] ? -28'sd11796480 : 28'sd11796480);

	assign xs = x_q >>> cmd.idx;
	assign ys = y_q >>> cmd.idx;
	assign at = atan_q16(cmd.idx);

	assign ang_full = (z_q + 28'sd128) >>> 8;
	assign ang      = zero_q ? '0 : ang_full[19:0];
	assign acc_r    = sat17(40'(ang) + 40'(acc_roll_trim_q) - 40'(mount_roll_q));
	assign acc_p    = sat17(40'(ang) + 40'(acc_pitch_trim_q) - 40'(mount_pitch_q));

	logic signed [16:0] acc_roll_q, acc_pitch_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ax_q <= accel_x;
			az_q <= accel_z;
		end
		if (cmd.start || cmd.save_roll) begin
			x_q    <= x_ld;
			y_q    <= y_ld;
			z_q    <= z_ld;
			zero_q <= (lx == '0) && (ly == '0);
		end else if (cmd.rot) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
		if (cmd.save_roll)
			acc_roll_q <= acc_r;
		if (cmd.save_pitch)
			acc_pitch_q <= acc_p;
	end

	// blend
	logic                 primed_q;
	logic signed [16:0]   roll_q, pitch_q, yaw_q;
	logic signed [16:0]   pred_r, pred_p, yaw_n;
	logic signed [17:0]   wa, wc;
	logic signed [34:0]   pr_m, pp_m, ar_m, ap_m;
	logic signed [34:0]   pr_s1, pp_s1, ar_s1, ap_s1;
	logic signed [16:0]   yaw_s1;
	logic signed [35:0]   sum_r, sum_p;
	logic signed [35:0]   shr_r, shr_p;

	assign pred_r = sat17(40'(roll_q) + 40'(inc_x) + 40'(gyr_roll_trim_q));
	assign pred_p = sat17(40'(pitch_q) + 40'(inc_y) + 40'(gyr_pitch_trim_q));
	assign yaw_n  = sat17(40'(yaw_q) + 40'(inc_z));
	assign wa     = $signed({2'b0, blend_q});
	assign wc     = 18'sd65536 - wa;
	assign pr_m   = wa * pred_r;
	assign pp_m   = wa * pred_p;
	assign ar_m   = wc * acc_roll_q;
	assign ap_m   = wc * acc_pitch_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			pr_s1  <= pr_m;
			pp_s1  <= pp_m;
			ar_s1  <= ar_m;
			ap_s1  <= ap_m;
			yaw_s1 <= yaw_n;
		end
	end

	assign sum_r = 36'(pr_s1) + 36'(ar_s1) + 36'sd32768;
	assign sum_p = 36'(pp_s1) + 36'(ap_s1) + 36'sd32768;
	assign shr_r = sum_r >>> 16;
	assign shr_p = sum_p >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			roll_q   <= '0;
			pitch_q  <= '0;
			yaw_q    <= '0;
		end else if (cmd.commit) begin
			primed_q <= 1'b1;
			if (!primed_q) begin
				roll_q  <= acc_roll_q;
				pitch_q <= acc_pitch_q;
				yaw_q   <= '0;
			end else begin
				roll_q  <= sat17(40'(shr_r));
				pitch_q <= sat17(40'(shr_p));
				yaw_q   <= yaw_s1;
			end
		end
	end

	assign roll_angle  = roll_q;
	assign pitch_angle = pitch_q;
	assign yaw_angle   = yaw_q;

endmodule

@@ sv/tilt_complementary_filter.sv @@
// ----------------------------------------------------------------------------
// tilt_complementary_filter
// Roll, pitch and yaw in Q8.8 degrees from raw accelerometer and gyro samples.
//
// s_* channel: one sample per transfer; s_tdata holds accel x/y/z, gyro x/y/z
// and elapsed milliseconds. m_* channel: one result per sample; m_tdata holds
// roll, pitch and yaw. cfg_we/cfg_addr/cfg_wdata write the seven tuning
// registers; write them only while no sample is in flight.
// A sample passes from its transfer to m_tvalid through the roll rotations,
// the pitch rotations, the blend multiply and the commit; the single CORDIC
// unit computes the roll and then the pitch atan2 in turn, and the gyro
// increments run alongside. One sample is processed at a time: s_tready
// returns in the cycle m_tvalid rises.
// A result waiting on m_tready does not block the next transfer on s_*; that
// sample runs to its end and then waits until the pending result is taken.
// Reset restores the register defaults and clears the estimates; the first
// sample after reset loads the accelerometer angles and zero yaw.
// ----------------------------------------------------------------------------
module tilt_complementary_filter #(
	parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, elapsed_ms (16 b each)
	input  logic [111:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// roll_angle, pitch_angle, yaw_angle (17 b each), 5 b zero pad
	output logic [55:0]  m_tdata
);
	import tcf_pkg::*;

	cmd_t               cmd;
	sts_t               sts;
	logic signed [16:0] roll, pitch, yaw;

	tcf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
		.sts, .cmd
	);

	tcf_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .cfg_we, .cfg_addr, .cfg_wdata,
		.accel_x(s_tdata[15:0]), .accel_y(s_tdata[31:16]),
		.accel_z(s_tdata[47:32]), .gyro_x(s_tdata[63:48]),
		.gyro_y(s_tdata[79:64]), .gyro_z(s_tdata[95:80]),
		.elapsed_ms(s_tdata[111:96]),
		.roll_angle(roll), .pitch_angle(pitch), .yaw_angle(yaw)
	);

	assign m_tdata = {5'b0, yaw, pitch, roll};

endmodule
